// ----- sv/tcs_pkg.sv -----
// tcs_pkg: sizes, codes and address helpers for the text console with scrollback
// no dependencies; imported by the top level module
`timescale 1ns / 1ps

package tcs_pkg;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int HIST_DEPTH = 200;

    localparam int SCR_DEPTH = ROWS * COLS;
    localparam int HIS_DEPTH = HIST_DEPTH * COLS;
    localparam int SCR_AW    = $clog2(SCR_DEPTH);
    localparam int HIS_AW    = $clog2(HIS_DEPTH);
    localparam int AW        = (SCR_AW > HIS_AW) ? SCR_AW : HIS_AW;

    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int X_W    = $clog2(COLS + 1);
    localparam int LOOP_W = $clog2(ROWS + 1);
    localparam int HW     = $clog2(HIST_DEPTH + 1);

    localparam logic [2:0] ACT_PUT   = 3'd0;
    localparam logic [2:0] ACT_BACK  = 3'd1;
    localparam logic [2:0] ACT_FWD   = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_COLOR = 3'd4;
    localparam logic [2:0] ACT_READ  = 3'd5;

    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // start address of a screen row or a history slot
    function automatic logic [AW-1:0] row_base(input logic [AW-1:0] r);
        logic [AW-1:0] c;
        c = AW'(COLS);
        return AW'(r * c);
    endfunction

endpackage

// ----- sv/tcs_if.sv -----
// tcs_in_if / tcs_out_if: valid-ready channels of the text console
// depends on nothing; used by the top level
`timescale 1ns / 1ps

interface tcs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] char_code;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, action, char_code, fg, bg, read_row, read_col,
                    input ready);
    modport sink (input valid, action, char_code, fg, bg, read_row, read_col,
                  output ready);
endinterface

interface tcs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [7:0]  view_back;
    logic [7:0]  history_count;

    modport source (output valid, cell_value, cursor_col, cursor_row, view_back,
                    history_count, input ready);
    modport sink (input valid, cell_value, cursor_col, cursor_row, view_back,
                  history_count, output ready);
endinterface

// ----- sv/tcs_ram.sv -----
// tcs_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/text_console_with_scrollback.sv -----
// text_console_with_scrollback: character terminal, screen ram plus history ring ram
// depends on tcs_pkg, tcs_if (channels) and tcs_ram
// row work moves one row at a time (newline scroll shifts every row up; scroll back may
// save the whole screen and then repaint it); one transaction at a time, bounded by
// the single ram ports
// reset: control clears at once, then a sweep zeroes the screen ram while input
// ready stays low; history ram is never cleared
`timescale 1ns / 1ps

module text_console_with_scrollback
    import tcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tcs_in_if.sink   in_ch,
    tcs_out_if.source out_ch
);

    typedef enum logic [3:0] {
        ST_FILL, ST_IDLE, ST_ROW, ST_PUT, ST_SAVE, ST_NEXT, ST_SCROLL,
        ST_LOOKB2, ST_PAINT, ST_READ, ST_READ_GET, ST_DONE
    } state_t;

    state_t state_reg;
    state_t ret_reg;

    // latched transaction
    logic [2:0] op_reg;
    logic [7:0] char_reg;
    logic [4:0] rd_row_reg;
    logic [6:0] rd_col_reg;
    logic [15:0] cell_reg;

    // console state
    logic [7:0]       attr_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [HW-1:0]    head_reg;
    logic [HW-1:0]    lines_reg;
    logic [HW-1:0]    view_reg;
    logic [HW-1:0]    base_reg;
    logic [LOOP_W-1:0] loop_reg;
    logic             init_reg;

    // row copy engine
    logic [X_W-1:0]   x_reg;
    logic [COL_W-1:0] px_reg;
    logic             pend_reg;
    logic             src_scr_reg;
    logic             fill_reg;
    logic             dst_his_reg;
    logic [15:0]      val_reg;
    logic [AW-1:0]    src_base_reg;
    logic [AW-1:0]    dst_base_reg;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_cell_reg;
    logic [6:0]  out_col_reg;
    logic [4:0]  out_row_reg;
    logic [7:0]  out_view_reg;
    logic [7:0]  out_hist_reg;

    logic [15:0] scr_rdata, his_rdata;
    logic        scr_we, his_we;
    logic [SCR_AW-1:0] scr_waddr, scr_raddr;
    logic [HIS_AW-1:0] his_waddr, his_raddr;
    logic [15:0] scr_wdata, row_data, blank;

    // job setup decoded from the current state
    logic          job_go, job_src_scr, job_fill, job_dst_his;
    logic [15:0]   job_val;
    logic [AW-1:0] job_src, job_dst;
    state_t        job_ret;

    logic [ROW_W-1:0] save_y;
    logic [HW-1:0]    head_adj, lines_adj, save_slot, paint_slot, live_base;
    logic [HW:0]      slot_sum, paint_idx, view_inc;
    logic [HW+1:0]    paint_sum;
    logic             paint_have, put_we, read_ok;
    logic [AW-1:0]    cur_addr, read_addr;

    assign blank = {attr_reg, CH_SP};

    always_comb
    begin
        // ring bookkeeping for a line save: drop the oldest when full
        save_y = (op_reg == ACT_PUT) ? row_reg : ROW_W'(loop_reg);
        if (lines_reg >= HW'(HIST_DEPTH))
        begin
            head_adj  = (head_reg == HW'(HIST_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            lines_adj = HW'(HIST_DEPTH - 1);
        end
        else
        begin
            head_adj  = head_reg;
            lines_adj = lines_reg;
        end
        slot_sum  = {1'b0, head_adj} + {1'b0, lines_adj};
        save_slot = (slot_sum >= (HW+1)'(HIST_DEPTH)) ?
                    HW'(slot_sum - (HW+1)'(HIST_DEPTH)) : HW'(slot_sum);

        // history line shown on screen row loop_reg
        paint_idx  = {1'b0, base_reg} + (HW+1)'(loop_reg);
        paint_have = paint_idx < {1'b0, lines_reg};
        paint_sum  = (HW+2)'(head_reg) + (HW+2)'(paint_idx);
        paint_slot = (paint_sum >= (HW+2)'(HIST_DEPTH)) ?
                     HW'(paint_sum - (HW+2)'(HIST_DEPTH)) : HW'(paint_sum);

        live_base = (int'(lines_reg) >= ROWS) ? HW'(int'(lines_reg) - ROWS) : '0;
        view_inc  = {1'b0, view_reg} + 1'b1;

        cur_addr  = row_base(AW'(row_reg)) +
                    ((char_reg == CH_BS) ? AW'(col_reg - 1'b1) : AW'(col_reg));
        read_addr = row_base(AW'(rd_row_reg)) + AW'(rd_col_reg);
        read_ok   = (int'(rd_row_reg) < ROWS) && (int'(rd_col_reg) < COLS);
    end

    always_comb
    begin
        job_go      = 1'b0;
        job_src_scr = 1'b1;
        job_fill    = 1'b0;
        job_dst_his = 1'b0;
        job_val     = '0;
        job_src     = '0;
        job_dst     = '0;
        job_ret     = ST_DONE;
        case (state_reg)
            ST_FILL:
            begin
                job_go   = loop_reg != LOOP_W'(ROWS);
                job_fill = 1'b1;
                job_val  = init_reg ? 16'h0000 : blank;
                job_dst  = row_base(AW'(loop_reg));
                job_ret  = ST_FILL;
            end
            ST_SAVE:
            begin
                job_go      = (op_reg == ACT_PUT) || (loop_reg != LOOP_W'(ROWS));
                job_src     = row_base(AW'(save_y));
                job_dst_his = 1'b1;
                job_dst     = row_base(AW'(save_slot));
                job_ret     = (op_reg == ACT_PUT) ? ST_NEXT : ST_SAVE;
            end
            ST_SCROLL:
            begin
                job_go = 1'b1;
                if (loop_reg != LOOP_W'(ROWS - 1))
                begin
                    job_src = row_base(AW'(loop_reg) + 1'b1);
                    job_dst = row_base(AW'(loop_reg));
                    job_ret = ST_SCROLL;
                end
                else
                begin
                    job_fill = 1'b1;
                    job_val  = blank;
                    job_dst  = row_base(AW'(ROWS - 1));
                    job_ret  = ST_DONE;
                end
            end
            ST_PAINT:
            begin
                job_go      = loop_reg != LOOP_W'(ROWS);
                job_src_scr = 1'b0;
                job_fill    = !paint_have;
                job_src     = row_base(AW'(paint_slot));
                job_dst     = row_base(AW'(loop_reg));
                job_ret     = ST_PAINT;
            end
            default:
            begin
                job_go = 1'b0;
            end
        endcase
    end

    // ram ports
    always_comb
    begin
        row_data = fill_reg ? val_reg : (src_scr_reg ? scr_rdata : his_rdata);
        put_we   = (state_reg == ST_PUT) && (char_reg != CH_NL) &&
                   !((char_reg == CH_BS) && (col_reg == '0));
        if (state_reg == ST_ROW)
        begin
            scr_we    = pend_reg && !dst_his_reg;
            scr_waddr = SCR_AW'(dst_base_reg + AW'(px_reg));
            scr_wdata = row_data;
            scr_raddr = SCR_AW'(src_base_reg + AW'(x_reg));
        end
        else
        begin
            scr_we    = put_we;
            scr_waddr = SCR_AW'(cur_addr);
            scr_wdata = (char_reg == CH_BS) ? blank : {attr_reg, char_reg};
            scr_raddr = SCR_AW'(read_addr);
        end
        his_we    = (state_reg == ST_ROW) && pend_reg && dst_his_reg;
        his_waddr = HIS_AW'(dst_base_reg + AW'(px_reg));
        his_raddr = HIS_AW'(src_base_reg + AW'(x_reg));
    end

    tcs_ram #(.WIDTH(16), .DEPTH(SCR_DEPTH)) u_screen (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_waddr),
        .wdata (scr_wdata),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    tcs_ram #(.WIDTH(16), .DEPTH(HIS_DEPTH)) u_history (
        .clk   (clk),
        .we    (his_we),
        .waddr (his_waddr),
        .wdata (row_data),
        .raddr (his_raddr),
        .rdata (his_rdata)
    );

    assign in_ch.ready          = (state_reg == ST_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.cell_value    = out_cell_reg;
    assign out_ch.cursor_col    = out_col_reg;
    assign out_ch.cursor_row    = out_row_reg;
    assign out_ch.view_back     = out_view_reg;
    assign out_ch.history_count = out_hist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            ret_reg       <= ST_DONE;
            op_reg        <= ACT_PUT;
            attr_reg      <= ATTR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            head_reg      <= '0;
            lines_reg     <= '0;
            view_reg      <= '0;
            base_reg      <= '0;
            loop_reg      <= '0;
            init_reg      <= 1'b1;
            x_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // ST_DONE reloads the result register on its own
            if (out_valid_reg && out_ch.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_FILL:
                begin
                    if (loop_reg == LOOP_W'(ROWS))
                    begin
                        state_reg <= init_reg ? ST_IDLE : ST_DONE;
                        init_reg  <= 1'b0;
                    end
                    else
                    begin
                        loop_reg <= loop_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        // take the transaction
                        op_reg     <= in_ch.action;
                        char_reg   <= in_ch.char_code;
                        rd_row_reg <= in_ch.read_row;
                        rd_col_reg <= in_ch.read_col;
                        cell_reg   <= '0;
                        loop_reg   <= '0;
                        case (in_ch.action)
                            ACT_PUT:
                            begin
                                // leaving the scrolled view repaints the live tail first
                                if (view_reg != '0)
                                begin
                                    view_reg  <= '0;
                                    base_reg  <= live_base;
                                    state_reg <= ST_PAINT;
                                end
                                else
                                begin
                                    state_reg <= ST_PUT;
                                end
                            end
                            ACT_BACK:
                            begin
                                state_reg <= (view_reg == '0) ? ST_SAVE : ST_LOOKB2;
                            end
                            ACT_FWD:
                            begin
                                if (view_reg == '0)
                                begin
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    view_reg  <= view_reg - 1'b1;
                                    base_reg  <= (view_reg == HW'(1)) ? live_base :
                                                 lines_reg - (view_reg - 1'b1);
                                    state_reg <= ST_PAINT;
                                end
                            end
                            ACT_CLEAR:
                            begin
                                col_reg   <= '0;
                                row_reg   <= '0;
                                state_reg <= ST_FILL;
                            end
                            ACT_COLOR:
                            begin
                                attr_reg  <= {in_ch.bg, in_ch.fg};
                                state_reg <= ST_DONE;
                            end
                            ACT_READ:
                            begin
                                state_reg <= ST_READ;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_PUT:
                begin
                    if (char_reg == CH_NL)
                    begin
                        state_reg <= ST_SAVE;
                    end
                    else if (char_reg == CH_BS)
                    begin
                        if (col_reg != '0)
                        begin
                            col_reg <= col_reg - 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                    else if (col_reg == COL_W'(COLS - 1))
                    begin
                        // wrap past the last column
                        state_reg <= ST_NEXT;
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_SAVE:
                begin
                    if (op_reg == ACT_PUT)
                    begin
                        head_reg  <= head_adj;
                        lines_reg <= lines_adj + 1'b1;
                    end
                    else if (loop_reg == LOOP_W'(ROWS))
                    begin
                        // whole screen saved, view starts one line back
                        view_reg  <= HW'(1);
                        state_reg <= ST_LOOKB2;
                    end
                    else
                    begin
                        head_reg  <= head_adj;
                        lines_reg <= lines_adj + 1'b1;
                        loop_reg  <= loop_reg + 1'b1;
                    end
                end
                ST_NEXT:
                begin
                    col_reg <= '0;
                    if (row_reg == ROW_W'(ROWS - 1))
                    begin
                        loop_reg  <= '0;
                        state_reg <= ST_SCROLL;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_SCROLL:
                begin
                    if (loop_reg != LOOP_W'(ROWS - 1))
                    begin
                        loop_reg <= loop_reg + 1'b1;
                    end
                end
                ST_LOOKB2:
                begin
                    if (view_inc < {1'b0, lines_reg})
                    begin
                        view_reg <= HW'(view_inc);
                        base_reg <= lines_reg - HW'(view_inc);
                    end
                    else
                    begin
                        base_reg <= lines_reg - view_reg;
                    end
                    loop_reg  <= '0;
                    state_reg <= ST_PAINT;
                end
                ST_PAINT:
                begin
                    if (loop_reg == LOOP_W'(ROWS))
                    begin
                        state_reg <= (op_reg == ACT_PUT) ? ST_PUT : ST_DONE;
                    end
                    else
                    begin
                        loop_reg <= loop_reg + 1'b1;
                    end
                end
                ST_ROW:
                begin
                    // read one cell a cycle, write it back in the next cycle
                    if (x_reg < X_W'(COLS))
                    begin
                        x_reg    <= x_reg + 1'b1;
                        px_reg   <= COL_W'(x_reg);
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            state_reg <= ret_reg;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= read_ok ? ST_READ_GET : ST_DONE;
                end
                ST_READ_GET:
                begin
                    cell_reg  <= scr_rdata;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cell_reg  <= cell_reg;
                        out_col_reg   <= 7'(col_reg);
                        out_row_reg   <= 5'(row_reg);
                        out_view_reg  <= 8'(view_reg);
                        out_hist_reg  <= 8'(lines_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // launch a row transfer; the states that launch one leave state_reg alone
            if (job_go)
            begin
                state_reg    <= ST_ROW;
                ret_reg      <= job_ret;
                x_reg        <= '0;
                pend_reg     <= 1'b0;
                src_scr_reg  <= job_src_scr;
                fill_reg     <= job_fill;
                dst_his_reg  <= job_dst_his;
                val_reg      <= job_val;
                src_base_reg <= job_src;
                dst_base_reg <= job_dst;
            end
        end
    end

endmodule
